// ----- src/tcf_pkg.sv -----
package tcf_pkg;

    localparam logic [7:0] BYTE_IAC  = 8'd255;
    localparam logic [7:0] BYTE_DONT = 8'd254;
    localparam logic [7:0] BYTE_DO   = 8'd253;
    localparam logic [7:0] BYTE_WONT = 8'd252;
    localparam logic [7:0] BYTE_WILL = 8'd251;
    localparam logic [7:0] BYTE_AYT  = 8'd246;
    localparam logic [7:0] OPT_ECHO  = 8'd1;

    localparam logic [1:0] DEST_APP   = 2'd0;
    localparam logic [1:0] DEST_ECHO  = 2'd1;
    localparam logic [1:0] DEST_REPLY = 2'd2;

    localparam int AYT_LEN = 7;
    localparam int IDX_W   = $clog2(AYT_LEN);

    // Reply to "are you there": "[YES]" followed by CR LF.
    function automatic logic [7:0] ayt_char(input logic [IDX_W-1:0] idx);
        logic [7:0] c;
        case (idx)
            3'd0:    c = 8'h5B;
            3'd1:    c = 8'h59;
            3'd2:    c = 8'h45;
            3'd3:    c = 8'h53;
            3'd4:    c = 8'h5D;
            3'd5:    c = 8'h0D;
            3'd6:    c = 8'h0A;
            default: c = 8'h0A;
        endcase
        return c;
    endfunction

endpackage

// ----- src/tcf_rx_if.sv -----
interface tcf_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;
    logic       hide_echo;
    logic       chunk_end;

    modport source (output valid, output rx_byte, output hide_echo, output chunk_end,
                    input ready);
    modport sink (input valid, input rx_byte, input hide_echo, input chunk_end,
                  output ready);
endinterface

// ----- src/tcf_tx_if.sv -----
interface tcf_tx_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic [1:0] out_dest;
    logic       last_of_run;

    modport source (output valid, output out_byte, output out_dest, output last_of_run,
                    input ready);
    modport sink (input valid, input out_byte, input out_dest, input last_of_run,
                  output ready);
endinterface

// ----- src/telnet_command_filter.sv -----
// The first result of a byte passes through the run register and then the result register.
// One result per cycle while the receiver is ready; a byte gives as many results as its run
// holds (two for an echoed data byte, seven for an AYT reply), and a dropped byte gives none.
// A new byte is taken once the run register is empty or is emitting its last result.
// Reset (asynchronous, active low) returns to the data phase with echo off and
// empties the run and result registers.
module telnet_command_filter
    import tcf_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    tcf_rx_if.sink   item,
    tcf_tx_if.source result
);

    typedef enum logic [2:0] {PH_DATA, PH_IAC, PH_DO, PH_DONT, PH_SKIP} phase_t;
    typedef enum logic [1:0] {RUN_DATA, RUN_REPLY, RUN_AYT} run_kind_t;

    phase_t           phase_reg, phase_next;
    logic             echo_reg, echo_next;

    logic             run_valid_reg;
    run_kind_t        run_kind_reg;
    logic [7:0]       run_byte_reg;
    logic [7:0]       run_cmd_reg;
    logic             run_echo_reg;
    logic [IDX_W-1:0] run_idx_reg;

    logic             out_valid_reg;
    logic [7:0]       out_byte_reg;
    logic [1:0]       out_dest_reg;
    logic             out_last_reg;

    logic             new_valid;
    run_kind_t        new_kind;
    logic [7:0]       new_cmd;
    logic             new_echo;

    logic             out_free;
    logic             emit;
    logic             run_done;
    logic             accept;
    logic [7:0]       elem_byte;
    logic [1:0]       elem_dest;
    logic             elem_last;

    always_comb
    begin
        phase_next = PH_DATA;
        echo_next  = echo_reg;
        new_valid  = 1'b0;
        new_kind   = RUN_DATA;
        new_cmd    = BYTE_WONT;
        new_echo   = echo_reg && !item.hide_echo;
        case (phase_reg)
            PH_IAC:
            begin
                if (item.rx_byte == BYTE_IAC)
                begin
                    new_valid = 1'b1;
                end
                else if (item.rx_byte == BYTE_AYT)
                begin
                    new_valid = 1'b1;
                    new_kind  = RUN_AYT;
                end
                else if (item.rx_byte == BYTE_DO)
                begin
                    phase_next = PH_DO;
                end
                else if (item.rx_byte == BYTE_DONT)
                begin
                    phase_next = PH_DONT;
                end
                else if (item.rx_byte == BYTE_WILL || item.rx_byte == BYTE_WONT)
                begin
                    phase_next = PH_SKIP;
                end
            end
            PH_DO:
            begin
                if (item.rx_byte == OPT_ECHO)
                begin
                    if (!echo_reg)
                    begin
                        new_valid = 1'b1;
                        new_kind  = RUN_REPLY;
                        new_cmd   = BYTE_WILL;
                        echo_next = 1'b1;
                    end
                end
                else
                begin
                    new_valid = 1'b1;
                    new_kind  = RUN_REPLY;
                end
            end
            PH_DONT:
            begin
                if (item.rx_byte == OPT_ECHO && echo_reg)
                begin
                    new_valid = 1'b1;
                    new_kind  = RUN_REPLY;
                    echo_next = 1'b0;
                end
            end
            PH_SKIP:
            begin
                phase_next = PH_DATA;
            end
            default:
            begin
                if (item.rx_byte == BYTE_IAC)
                begin
                    phase_next = PH_IAC;
                end
                else
                begin
                    new_valid = 1'b1;
                end
            end
        endcase
    end

    always_comb
    begin
        elem_byte = run_byte_reg;
        elem_dest = DEST_REPLY;
        elem_last = 1'b0;
        case (run_kind_reg)
            RUN_DATA:
            begin
                elem_dest = (run_echo_reg && run_idx_reg == '0) ? DEST_ECHO : DEST_APP;
                elem_last = !run_echo_reg || run_idx_reg != '0;
            end
            RUN_REPLY:
            begin
                case (run_idx_reg)
                    3'd0:    elem_byte = BYTE_IAC;
                    3'd1:    elem_byte = run_cmd_reg;
                    default: elem_byte = run_byte_reg;
                endcase
                elem_last = run_idx_reg == 3'd2;
            end
            RUN_AYT:
            begin
                elem_byte = ayt_char(run_idx_reg);
                elem_last = run_idx_reg == IDX_W'(AYT_LEN - 1);
            end
            default:
            begin
                elem_last = 1'b1;
            end
        endcase
    end

    assign out_free   = !out_valid_reg || result.ready;
    assign emit       = run_valid_reg && out_free;
    assign run_done   = emit && elem_last;
    assign item.ready = !run_valid_reg || run_done;
    assign accept     = item.valid && item.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_DATA;
            echo_reg      <= 1'b0;
            run_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                phase_reg <= phase_next;
                echo_reg  <= echo_next;
            end
            if (accept && new_valid)
            begin
                run_valid_reg <= 1'b1;
            end
            else if (run_done)
            begin
                run_valid_reg <= 1'b0;
            end
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && new_valid)
        begin
            run_kind_reg <= new_kind;
            run_byte_reg <= item.rx_byte;
            run_cmd_reg  <= new_cmd;
            run_echo_reg <= new_echo;
            run_idx_reg  <= '0;
        end
        else if (emit)
        begin
            run_idx_reg <= IDX_W'(run_idx_reg + 1'b1);
        end
        if (emit)
        begin
            out_byte_reg <= elem_byte;
            out_dest_reg <= elem_dest;
            out_last_reg <= elem_last;
        end
    end

    assign result.valid       = out_valid_reg;
    assign result.out_byte    = out_byte_reg;
    assign result.out_dest    = out_dest_reg;
    assign result.last_of_run = out_last_reg;

endmodule

// ----- src/tcf_checker.sv -----
module tcf_checker
    import tcf_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       res_valid,
    input logic       res_ready,
    input logic [7:0] out_byte,
    input logic [1:0] out_dest,
    input logic       last_of_run
);

    // An echo never closes its run: the delivery of the same byte comes after it.
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && out_dest == DEST_ECHO |-> !last_of_run)
        else $error("echo transaction marked as last of its run");

    // A delivery to the application always closes its run.
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && out_dest == DEST_APP |-> last_of_run)
        else $error("delivery transaction not marked as last of its run");

    // After an echo is taken, the next result is the delivery of that byte.
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_ready && out_dest == DEST_ECHO
        |=> !res_valid || (out_dest == DEST_APP && out_byte == $past(out_byte)))
        else $error("echo not followed by delivery of the same byte");

    // A stalled result holds.
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready
        |=> res_valid && $stable(out_byte) && $stable(out_dest) && $stable(last_of_run))
        else $error("stalled result transaction changed");

endmodule

bind telnet_command_filter tcf_checker u_tcf_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .res_valid   (result.valid),
    .res_ready   (result.ready),
    .out_byte    (result.out_byte),
    .out_dest    (result.out_dest),
    .last_of_run (result.last_of_run)
);

// ----- verif/telnet_command_filter_tb.sv -----
`timescale 1ns / 1ps

module telnet_command_filter_tb;
    import tcf_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_CYCLES = 20;
    localparam int RANDOM_BYTES = 300;
    // "[YES]" followed by CR LF, first character in the top byte.
    localparam logic [55:0] YES_REPLY = 56'h5B5945535D0D0A;

    typedef enum logic [2:0] {
        ST_DATA,
        ST_AFTER_IAC,
        ST_AFTER_DO,
        ST_AFTER_DONT,
        ST_SKIP_OPT
    } parse_state_t;

    typedef struct packed {
        logic [7:0] data;
        logic [1:0] dest;
        logic       last;
    } tx_beat_t;

    logic clk;
    logic rst_n;

    tcf_rx_if rx_chan ();
    tcf_tx_if tx_chan ();

    telnet_command_filter dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (rx_chan),
        .result (tx_chan)
    );

    parse_state_t parse_state;
    logic         echo_active;
    tx_beat_t     run_beats[$];
    tx_beat_t     awaited_beats[$];
    tx_beat_t     head_beat;
    logic         allow_gaps;
    int           error_count;
    int           cycle_count;
    int           bytes_sent;

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    initial
    begin
        rst_n             = 1'b0;
        rx_chan.valid     = 1'b0;
        rx_chan.rx_byte   = 8'd0;
        rx_chan.hide_echo = 1'b0;
        rx_chan.chunk_end = 1'b0;
        tx_chan.ready     = 1'b0;
    end

    always @(negedge clk)
    begin
        tx_chan.ready <= !(allow_gaps && $urandom_range(99) < 31);
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && tx_chan.valid && tx_chan.ready)
        begin
            if (awaited_beats.size() == 0)
            begin
                $display("%0t: unexpected transaction, expected none, got byte %02h dest %0d last %0b",
                         $time, tx_chan.out_byte, tx_chan.out_dest, tx_chan.last_of_run);
                error_count++;
            end
            else
            begin
                head_beat = awaited_beats.pop_front();
                if (tx_chan.out_byte !== head_beat.data)
                begin
                    $display("%0t: out_byte expected %02h, got %02h",
                             $time, head_beat.data, tx_chan.out_byte);
                    error_count++;
                end
                if (tx_chan.out_dest !== head_beat.dest)
                begin
                    $display("%0t: out_dest expected %0d, got %0d",
                             $time, head_beat.dest, tx_chan.out_dest);
                    error_count++;
                end
                if (tx_chan.last_of_run !== head_beat.last)
                begin
                    $display("%0t: last_of_run expected %0b, got %0b",
                             $time, head_beat.last, tx_chan.last_of_run);
                    error_count++;
                end
            end
        end
    end

    task automatic add_beat(input logic [7:0] data, input logic [1:0] dest);
        tx_beat_t beat;
        beat.data = data;
        beat.dest = dest;
        beat.last = 1'b0;
        run_beats.push_back(beat);
    endtask

    task automatic add_reply(input logic [7:0] cmd, input logic [7:0] opt);
        add_beat(BYTE_IAC, DEST_REPLY);
        add_beat(cmd, DEST_REPLY);
        add_beat(opt, DEST_REPLY);
    endtask

    task automatic add_data(input logic [7:0] data, input logic hide);
        if (echo_active && !hide)
            add_beat(data, DEST_ECHO);
        add_beat(data, DEST_APP);
    endtask

    task automatic predict_filter(input logic [7:0] data, input logic hide);
        tx_beat_t beat;
        run_beats.delete();
        case (parse_state)
            ST_AFTER_IAC:
            begin
                parse_state = ST_DATA;
                if (data == BYTE_IAC)
                    add_data(data, hide);
                else if (data == BYTE_AYT)
                begin
                    for (int i = 0; i < 7; i++)
                        add_beat(YES_REPLY[55 - 8 * i -: 8], DEST_REPLY);
                end
                else if (data == BYTE_DO)
                    parse_state = ST_AFTER_DO;
                else if (data == BYTE_DONT)
                    parse_state = ST_AFTER_DONT;
                else if (data == BYTE_WILL || data == BYTE_WONT)
                    parse_state = ST_SKIP_OPT;
            end
            ST_AFTER_DO:
            begin
                parse_state = ST_DATA;
                if (data == OPT_ECHO)
                begin
                    if (!echo_active)
                    begin
                        add_reply(BYTE_WILL, data);
                        echo_active = 1'b1;
                    end
                end
                else
                    add_reply(BYTE_WONT, data);
            end
            ST_AFTER_DONT:
            begin
                parse_state = ST_DATA;
                if (data == OPT_ECHO && echo_active)
                begin
                    add_reply(BYTE_WONT, data);
                    echo_active = 1'b0;
                end
            end
            ST_SKIP_OPT:
                parse_state = ST_DATA;
            default:
            begin
                parse_state = ST_DATA;
                if (data == BYTE_IAC)
                    parse_state = ST_AFTER_IAC;
                else
                    add_data(data, hide);
            end
        endcase
        for (int i = 0; i < run_beats.size(); i++)
        begin
            beat = run_beats[i];
            beat.last = (i == run_beats.size() - 1);
            awaited_beats.push_back(beat);
        end
    endtask

    task automatic send_byte(input logic [7:0] data, input logic hide, input logic chunk);
        @(negedge clk);
        while (allow_gaps && $urandom_range(99) < 31)
        begin
            rx_chan.valid <= 1'b0;
            @(negedge clk);
        end
        rx_chan.valid     <= 1'b1;
        rx_chan.rx_byte   <= data;
        rx_chan.hide_echo <= hide;
        rx_chan.chunk_end <= chunk;
        @(posedge clk);
        while (!rx_chan.ready)
            @(posedge clk);
        bytes_sent++;
        predict_filter(data, hide);
    endtask

    task automatic send_command(input logic [7:0] cmd, input logic [7:0] opt,
                                input logic hide, input logic chunk);
        send_byte(BYTE_IAC, hide, 1'b0);
        send_byte(cmd, !hide, 1'b0);
        send_byte(opt, hide, chunk);
    endtask

    task automatic wait_drained();
        @(negedge clk);
        rx_chan.valid <= 1'b0;
        while (awaited_beats.size() != 0)
            @(posedge clk);
    endtask

    task automatic test_plain_bytes();
        send_byte(8'h00, 1'b0, 1'b0);
        send_byte(8'hFE, 1'b1, 1'b1);
        wait_drained();
    endtask

    task automatic test_are_you_there();
        send_byte(BYTE_IAC, 1'b0, 1'b1);
        send_byte(BYTE_AYT, 1'b1, 1'b0);
        wait_drained();
    endtask

    task automatic test_echo_negotiation();
        send_command(BYTE_DO, OPT_ECHO, 1'b0, 1'b1);
        send_command(BYTE_DO, OPT_ECHO, 1'b1, 1'b0);
        send_byte(8'h7F, 1'b0, 1'b0);
        send_byte(BYTE_IAC, 1'b0, 1'b0);
        send_byte(BYTE_IAC, 1'b1, 1'b1);
        send_byte(BYTE_IAC, 1'b0, 1'b0);
        send_byte(BYTE_IAC, 1'b0, 1'b0);
        send_command(BYTE_DO, 8'h00, 1'b0, 1'b0);
        send_command(BYTE_DONT, OPT_ECHO, 1'b0, 1'b1);
        send_command(BYTE_DONT, OPT_ECHO, 1'b1, 1'b0);
        wait_drained();
    endtask

    task automatic test_ignored_commands();
        send_command(BYTE_WILL, 8'hFF, 1'b0, 1'b0);
        send_byte(BYTE_IAC, 1'b1, 1'b0);
        send_byte(8'd250, 1'b0, 1'b1);
        wait_drained();
    endtask

    task automatic send_random_sequence();
        int          kind;
        logic [7:0]  opt;
        logic        hide;
        logic        chunk;
        kind  = $urandom_range(99);
        hide  = ($urandom_range(3) == 0);
        chunk = $urandom_range(1);
        opt   = $urandom_range(1) ? OPT_ECHO : 8'($urandom_range(255));
        if (kind < 10)
            send_byte(8'($urandom_range(255)), hide, chunk);
        else if (kind < 40)
            send_byte(8'($urandom_range(254)), hide, chunk);
        else if (kind < 48)
        begin
            send_byte(BYTE_IAC, !hide, 1'b0);
            send_byte(BYTE_IAC, hide, chunk);
        end
        else if (kind < 55)
        begin
            send_byte(BYTE_IAC, hide, chunk);
            send_byte(BYTE_AYT, hide, 1'b0);
        end
        else if (kind < 70)
            send_command(BYTE_DO, opt, hide, chunk);
        else if (kind < 82)
            send_command(BYTE_DONT, opt, hide, chunk);
        else if (kind < 94)
            send_command($urandom_range(1) ? BYTE_WILL : BYTE_WONT,
                         8'($urandom_range(255)), hide, chunk);
        else
        begin
            send_byte(BYTE_IAC, hide, 1'b0);
            send_byte(8'($urandom_range(255)), !hide, chunk);
        end
    endtask

    task automatic test_random_traffic();
        int target;
        target = bytes_sent + RANDOM_BYTES;
        while (bytes_sent < target - 2 * RANDOM_BYTES / 3)
            send_random_sequence();
        wait_drained();
        allow_gaps = 1'b0;
        while (bytes_sent < target - RANDOM_BYTES / 3)
            send_random_sequence();
        allow_gaps = 1'b1;
        while (bytes_sent < target)
            send_random_sequence();
        wait_drained();
    endtask

    initial
    begin
        parse_state = ST_DATA;
        echo_active = 1'b0;
        allow_gaps  = 1'b1;
        error_count = 0;
        cycle_count = 0;
        bytes_sent  = 0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_plain_bytes();
        test_are_you_there();
        test_echo_negotiation();
        test_ignored_commands();
        test_random_traffic();

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
